FILE: hdl/twrm_pkg.sv
// ----------------------------------------------------------------------------
// twrm_pkg
// shared types and constants for the traffic window rate meter
// ----------------------------------------------------------------------------
package twrm_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int SUM_W         = 26;
  localparam int TICK_W        = 32;
  localparam int SIZE_W        = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);

  // register indexes of the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_WIN = 2'd0,
    CFG_LONG_WIN  = 2'd1,
    CFG_REUSE_AGE = 2'd2
  } cfg_idx_t;

  // request codes
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // direction codes
  localparam logic DIR_RX = 1'b0;
  localparam logic DIR_TX = 1'b1;

  // one slot of the packet table
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [TICK_W-1:0] stamp;
    logic              dir;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hdl/twrm_ram.sv
// ----------------------------------------------------------------------------
// twrm_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module twrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/traffic_window_rate_meter_top.sv
// ----------------------------------------------------------------------------
// traffic_window_rate_meter_top
// sliding-window byte rate meter over a table of packet records
// ----------------------------------------------------------------------------
// usage
//   an item is taken at a clock edge with start high and busy low. a record
//   item (in_req_type 0) adds the packet to the running totals of its
//   direction and stores it in the lowest slot that is free or has reached
//   the reuse age; out_dropped flags a packet that found no slot. a query
//   item (in_req_type 1) sums slot sizes per direction inside the short and
//   long windows and frees slots at or past the long window.
//   every item gives exactly one result, shown for one cycle with out_valid
//   high; the receiver cannot stall it, and busy stays low from then on so
//   the next item may be taken in that very cycle.
//   the slot table lives in one ram, scanned one entry per cycle with a
//   read, a compare and a write-back, so the ram port sets the rate;
//   a record scan stops at the slot that it fills, or runs to the last
//   slot when the table is full, and a query scan runs over every slot.
//   after reset a clearing pass writes every slot to zero, one slot per
//   cycle, with busy high; config writes go through at any time and the
//   totals and registers take their reset values.
// ----------------------------------------------------------------------------
module traffic_window_rate_meter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [twrm_pkg::TICK_W-1:0]   in_now_ticks,
  input  logic [twrm_pkg::SIZE_W-1:0]   in_packet_bytes,
  input  logic                          in_direction,
  // result channel
  output logic                          out_valid,
  output logic                          out_dropped,
  output logic [twrm_pkg::SUM_W-1:0]    out_rx_sec_bytes,
  output logic [twrm_pkg::SUM_W-1:0]    out_tx_sec_bytes,
  output logic [twrm_pkg::SUM_W-1:0]    out_rx_min_bytes,
  output logic [twrm_pkg::SUM_W-1:0]    out_tx_min_bytes,
  output logic [31:0]                   out_packets_sent,
  output logic [31:0]                   out_packets_received,
  output logic [63:0]                   out_bytes_sent,
  output logic [63:0]                   out_bytes_received,
  // config write port
  input  logic                          cfg_we,
  input  logic [twrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);

  import twrm_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN
  } state_t;

  // control state
  state_t             state_r;
  logic [IDX_W-1:0]   clr_idx_r;
  logic [CNT_W-1:0]   rd_cnt_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   ev_idx_r;
  logic               out_valid_r;

  // window registers
  logic [TICK_W-1:0]  short_win_r;
  logic [TICK_W-1:0]  long_win_r;
  logic [TICK_W-1:0]  reuse_age_r;

  // running totals
  logic [31:0]        sent_cnt_r;
  logic [31:0]        recv_cnt_r;
  logic [63:0]        sent_bytes_r;
  logic [63:0]        recv_bytes_r;

  // latched item
  logic               req_r;
  logic [TICK_W-1:0]  now_r;
  logic [SIZE_W-1:0]  bytes_r;
  logic               dir_r;

  // window sums under way
  logic [SUM_W-1:0]   rx_sec_r, tx_sec_r, rx_min_r, tx_min_r;
  logic [SUM_W-1:0]   rx_sec_nxt, tx_sec_nxt, rx_min_nxt, tx_min_nxt;

  // registered result fields
  logic               dropped_r;
  logic [SUM_W-1:0]   out_rx_sec_r, out_tx_sec_r, out_rx_min_r, out_tx_min_r;

  // ram port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_ent;

  // per-entry evaluation
  logic               accept;
  logic               scan_eval;
  logic [TICK_W-1:0]  age;
  logic               rec_hit;
  logic               in_long;
  logic               in_short;
  logic               ev_last;
  logic               scan_done;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]  a,
                                              input logic [SIZE_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign rd_ent    = entry_t'(ram_rdata);
  assign scan_eval = (state_r == S_SCAN) && rd_vld_r;
  assign age       = now_r - rd_ent.stamp;
  assign rec_hit   = (rd_ent.size == '0) || (age >= reuse_age_r);
  assign in_long   = age < long_win_r;
  assign in_short  = age < short_win_r;
  assign ev_last   = (ev_idx_r == LAST_IDX);
  assign scan_done = scan_eval && (ev_last || ((req_r == REQ_RECORD) && rec_hit));

  // reads run ahead one entry of the evaluation; each entry is written at
  // most once, in the cycle it is evaluated, so read and write never meet
  assign ram_re = (state_r == S_SCAN) && (rd_cnt_r < ENTRIES_CNT);

  // window sums, saturating
  always_comb begin
    rx_sec_nxt = rx_sec_r;
    tx_sec_nxt = tx_sec_r;
    rx_min_nxt = rx_min_r;
    tx_min_nxt = tx_min_r;
    if (scan_eval && (req_r == REQ_QUERY) && in_long) begin
      if (rd_ent.dir == DIR_TX) begin
        tx_min_nxt = sat_add(tx_min_r, rd_ent.size);
        if (in_short) begin
          tx_sec_nxt = sat_add(tx_sec_r, rd_ent.size);
        end
      end else begin
        rx_min_nxt = sat_add(rx_min_r, rd_ent.size);
        if (in_short) begin
          rx_sec_nxt = sat_add(rx_sec_r, rd_ent.size);
        end
      end
    end
  end

  // write port: clearing pass, slot fill on record, slot free on query
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx_r;
    ram_wdata = rd_ent;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else if (scan_eval) begin
      if (req_r == REQ_RECORD) begin
        ram_we          = rec_hit;
        ram_wdata.size  = bytes_r;
        ram_wdata.stamp = now_r;
        ram_wdata.dir   = dir_r;
      end else begin
        ram_we         = !in_long;
        ram_wdata.size = '0;
      end
    end
  end

  twrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    // payload, no reset needed
    if (accept) begin
      req_r    <= in_req_type;
      now_r    <= in_now_ticks;
      bytes_r  <= in_packet_bytes;
      dir_r    <= in_direction;
      rx_sec_r <= '0;
      tx_sec_r <= '0;
      rx_min_r <= '0;
      tx_min_r <= '0;
    end else begin
      rx_sec_r <= rx_sec_nxt;
      tx_sec_r <= tx_sec_nxt;
      rx_min_r <= rx_min_nxt;
      tx_min_r <= tx_min_nxt;
    end
    if (scan_done) begin
      dropped_r    <= (req_r == REQ_RECORD) && !rec_hit;
      out_rx_sec_r <= rx_sec_nxt;
      out_tx_sec_r <= tx_sec_nxt;
      out_rx_min_r <= rx_min_nxt;
      out_tx_min_r <= tx_min_nxt;
    end
    ev_idx_r <= rd_cnt_r[IDX_W-1:0];

    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      short_win_r <= 32'd1000;
      long_win_r  <= 32'd60000;
      reuse_age_r <= 32'd61000;
      sent_cnt_r   <= '0;
      recv_cnt_r   <= '0;
      sent_bytes_r <= '0;
      recv_bytes_r <= '0;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SHORT_WIN: short_win_r <= cfg_wdata;
          CFG_LONG_WIN:  long_win_r  <= cfg_wdata;
          CFG_REUSE_AGE: reuse_age_r <= cfg_wdata;
          default: ;
        endcase
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r  <= S_SCAN;
            rd_cnt_r <= '0;
            rd_vld_r <= 1'b0;
            // totals show the item's effect as soon as it is taken
            if (in_req_type == REQ_RECORD) begin
              if (in_direction == DIR_TX) begin
                sent_cnt_r   <= sent_cnt_r + 1'b1;
                sent_bytes_r <= sent_bytes_r + 64'(in_packet_bytes);
              end else begin
                recv_cnt_r   <= recv_cnt_r + 1'b1;
                recv_bytes_r <= recv_bytes_r + 64'(in_packet_bytes);
              end
            end
          end
        end
        S_SCAN: begin
          rd_vld_r <= ram_re;
          if (ram_re) begin
            rd_cnt_r <= rd_cnt_r + 1'b1;
          end
          if (scan_done) begin
            state_r     <= S_IDLE;
            rd_vld_r    <= 1'b0;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_dropped          = dropped_r;
  assign out_rx_sec_bytes     = out_rx_sec_r;
  assign out_tx_sec_bytes     = out_tx_sec_r;
  assign out_rx_min_bytes     = out_rx_min_r;
  assign out_tx_min_bytes     = out_tx_min_r;
  assign out_packets_sent     = sent_cnt_r;
  assign out_packets_received = recv_cnt_r;
  assign out_bytes_sent       = sent_bytes_r;
  assign out_bytes_received   = recv_bytes_r;

endmodule
